// ----- hw/rtl/lspp_pkg.sv -----
// Package for the scan packet parser: phase codes, descriptor bytes,
// the measurement record type and the queue status type.
// No dependencies.
`default_nettype none

package lspp_pkg;

  // Parse phases: the descriptor bytes first, then the five packet bytes.
  localparam logic [3:0] PhHuntFirst = 4'd0;
  localparam logic [3:0] PhHuntLast  = 4'd6;
  localparam logic [3:0] PhWaitStart = 4'd7;
  localparam logic [3:0] PhAngLo     = 4'd8;
  localparam logic [3:0] PhAngHi     = 4'd9;
  localparam logic [3:0] PhDistLo    = 4'd10;
  localparam logic [3:0] PhDistHi    = 4'd11;

  // The phase after the first two descriptor bytes, used when resynchronising.
  localparam logic [3:0] PhHuntThird = 4'd2;

  localparam logic [7:0] HeadByte0 = 8'hA5;
  localparam logic [7:0] HeadByte1 = 8'h5A;

  localparam logic [5:0] MinQualityReset = 6'd5;

  // Queue depth between the parser and the output stage.
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [5:0]  quality;
    logic [14:0] angle_q6;
    logic [15:0] distance;
  } meas_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

  // Expected response descriptor byte for each hunting phase.
  function automatic logic [7:0] descriptor_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'hA5;
      3'd1:    val = 8'h5A;
      3'd2:    val = 8'h05;
      3'd3:    val = 8'h00;
      3'd4:    val = 8'h00;
      3'd5:    val = 8'h40;
      3'd6:    val = 8'h81;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lidar_scan_packet_parser_top.sv -----
// Top level of the scan packet parser: parser front end, queue and output
// stage. Depends on lspp_pkg, lspp_front, lspp_queue and lspp_back.
//
// Usage:
//   Input channel (in_valid, in_ready, rx_byte) carries one received byte per
//   request. The parser first hunts for the descriptor A5 5A 05 00 00 40 81,
//   then decodes five-byte measurement packets.
//   Output channel (out_valid, out_ready, quality, angle_q6, distance) carries
//   one measurement per packet whose quality exceeds the threshold.
//   Configuration channel (cfg_valid, cfg_ready, min_quality) writes the
//   threshold; cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   One byte per cycle is accepted while the queue has room. A result passes
//   from the queue entry written at the edge that accepts the last byte of its
//   packet into the result register that drives the output, once that is free.
// Reset:
//   Synchronous rst returns the parser to the hunt for the descriptor, empties
//   the queue and the output register, and sets the threshold to 5.
// Stalls:
//   A two-entry queue and the result register absorb results while out_ready
//   is low; in_ready drops only when the queue is full.
`default_nettype none

module lidar_scan_packet_parser_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  rx_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [5:0]  quality,
  output logic [14:0] angle_q6,
  output logic [15:0] distance,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [5:0]  min_quality
);

  lspp_pkg::queue_status_t q_status;
  lspp_pkg::meas_t         push_data;
  lspp_pkg::meas_t         pop_data;
  logic                    push;
  logic                    pop;

  assign cfg_ready = 1'b1;

  // Byte parser.
  lspp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .cfg_valid   (cfg_valid),
    .min_quality (min_quality),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  // Decoupling queue.
  lspp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // Result register.
  lspp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .quality   (quality),
    .angle_q6  (angle_q6),
    .distance  (distance)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/lspp_front.sv -----
// Front end of the scan packet parser: takes received bytes, hunts for the
// descriptor, decodes packets and pushes qualifying measurements to the queue.
// Depends on lspp_pkg.
`default_nettype none

module lspp_front (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [7:0]             rx_byte,
  input  wire                    cfg_valid,
  input  wire  [5:0]             min_quality,
  input  lspp_pkg::queue_status_t q_status,
  output logic                   push,
  output lspp_pkg::meas_t        push_data
);

  logic [3:0] phase;
  logic [3:0] phase_next;
  logic [3:0] ph_eff;
  logic [5:0] thresh;
  logic [5:0] held_quality;
  logic [5:0] held_quality_next;
  logic [6:0] angle_low_bits;
  logic [6:0] angle_low_bits_next;
  logic [7:0] angle_high_bits;
  logic [7:0] angle_high_bits_next;
  logic [7:0] distance_low_byte;
  logic [7:0] distance_low_byte_next;
  logic       resync_pending;
  logic       resync_pending_next;
  logic       take;

  // A request is taken whenever the queue has room for a possible result.
  assign in_ready = !q_status.full;
  assign take     = in_valid && in_ready;

  // Unused phase codes behave as the first hunting phase.
  assign ph_eff = (phase > lspp_pkg::PhDistHi) ? lspp_pkg::PhHuntFirst : phase;

  // The finished record is built from the held fields and the last byte.
  assign push_data.quality  = held_quality;
  assign push_data.angle_q6 = {angle_high_bits, angle_low_bits};
  assign push_data.distance = {rx_byte, distance_low_byte};

  // Parser state machine.
  always_comb begin
    phase_next             = phase;
    held_quality_next      = held_quality;
    angle_low_bits_next    = angle_low_bits;
    angle_high_bits_next   = angle_high_bits;
    distance_low_byte_next = distance_low_byte;
    resync_pending_next    = resync_pending;
    push                   = 1'b0;
    if (take) begin
      if (ph_eff inside {[lspp_pkg::PhHuntFirst:lspp_pkg::PhHuntLast]}) begin
        if (rx_byte == lspp_pkg::descriptor_byte(ph_eff[2:0])) begin
          phase_next = ph_eff + 4'd1;
        end else begin
          phase_next = ph_eff;
        end
      end else begin
        case (ph_eff)
          lspp_pkg::PhWaitStart: begin
            // A start byte carries a flag and its complement in the low bits.
            if (rx_byte[0] != rx_byte[1]) begin
              held_quality_next   = rx_byte[7:2];
              resync_pending_next = (rx_byte == lspp_pkg::HeadByte0);
              phase_next          = lspp_pkg::PhAngLo;
            end
          end
          lspp_pkg::PhAngLo: begin
            // A5 followed by 5A is taken as the start of a new descriptor.
            if (resync_pending && (rx_byte == lspp_pkg::HeadByte1)) begin
              phase_next = lspp_pkg::PhHuntThird;
            end else begin
              angle_low_bits_next = rx_byte[7:1];
              phase_next          = lspp_pkg::PhAngHi;
            end
            resync_pending_next = 1'b0;
          end
          lspp_pkg::PhAngHi: begin
            angle_high_bits_next = rx_byte;
            phase_next           = lspp_pkg::PhDistLo;
          end
          lspp_pkg::PhDistLo: begin
            distance_low_byte_next = rx_byte;
            phase_next             = lspp_pkg::PhDistHi;
          end
          default: begin
            push       = (held_quality > thresh);
            phase_next = lspp_pkg::PhWaitStart;
          end
        endcase
      end
    end
  end

  // State registers and the quality threshold.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= lspp_pkg::PhHuntFirst;
      thresh            <= lspp_pkg::MinQualityReset;
      held_quality      <= '0;
      angle_low_bits    <= '0;
      angle_high_bits   <= '0;
      distance_low_byte <= '0;
      resync_pending    <= 1'b0;
    end else begin
      phase             <= phase_next;
      held_quality      <= held_quality_next;
      angle_low_bits    <= angle_low_bits_next;
      angle_high_bits   <= angle_high_bits_next;
      distance_low_byte <= distance_low_byte_next;
      resync_pending    <= resync_pending_next;
      if (cfg_valid) begin
        thresh <= min_quality;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lspp_queue.sv -----
// Short measurement queue between the parser and the output stage.
// Depends on lspp_pkg.
`default_nettype none

module lspp_queue (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  lspp_pkg::meas_t         push_data,
  input  wire                     pop,
  output lspp_pkg::meas_t         pop_data,
  output lspp_pkg::queue_status_t status
);

  lspp_pkg::meas_t                  entries [lspp_pkg::QueueDepth];
  logic [lspp_pkg::QueuePtrW-1:0] wptr;
  logic [lspp_pkg::QueuePtrW-1:0] rptr;
  logic [lspp_pkg::QueueCntW-1:0] count;
  logic                           do_push;
  logic                           do_pop;

  localparam logic [lspp_pkg::QueueCntW-1:0] CountFull =
    lspp_pkg::QueueCntW'(lspp_pkg::QueueDepth);
  localparam logic [lspp_pkg::QueuePtrW-1:0] PtrLast =
    lspp_pkg::QueuePtrW'(lspp_pkg::QueueDepth - 1);

  assign status.full      = (count == CountFull);
  assign status.not_empty = (count != '0);
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign pop_data         = entries[rptr];

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PtrLast) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PtrLast) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lspp_back.sv -----
// Output stage of the scan packet parser: a result register fed from the
// queue and drained by the receiver. Depends on lspp_pkg.
`default_nettype none

module lspp_back (
  input  wire                     clk,
  input  wire                     rst,
  input  lspp_pkg::queue_status_t q_status,
  input  lspp_pkg::meas_t         q_data,
  output logic                    pop,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [5:0]              quality,
  output logic [14:0]             angle_q6,
  output logic [15:0]             distance
);

  lspp_pkg::meas_t held;

  // Load a new result when the register is empty or being drained.
  assign pop = q_status.not_empty && (!out_valid || out_ready);

  assign quality  = held.quality;
  assign angle_q6 = held.angle_q6;
  assign distance = held.distance;

  always_ff @(posedge clk) begin
    if (pop) begin
      held <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lspp_checker.sv -----
// Port-level checker for the scan packet parser, bound to the top level.
// Depends on lidar_scan_packet_parser_top.
`default_nettype none

module lspp_port_checks (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [5:0]  quality,
  input wire [14:0] angle_q6,
  input wire [15:0] distance
);

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // A result only passes a strictly exceeded threshold, so quality is never zero.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (quality != 6'd0))
    else $error("result with zero quality");

  // A fresh result follows an accepted byte, through the queue entry and the result register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a preceding byte");

  // A stalled result holds its fields.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(quality) && $stable(angle_q6) && $stable(distance)))
    else $error("stalled result changed");

endmodule

bind lidar_scan_packet_parser_top lspp_port_checks u_lspp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .quality   (quality),
  .angle_q6  (angle_q6),
  .distance  (distance)
);

`default_nettype wire
